// ===== rtl/core/cca_pkg.sv =====
// ----------------------------------------------------------------------------
// cca_pkg: calendar clock advance package
// Field widths, range limits and the calendar helpers (leap year test and
// month length) shared by the calendar clock logic.
// ----------------------------------------------------------------------------
package cca_pkg;

  localparam int unsigned YEAR_W   = 16;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECOND_W = 6;
  localparam int unsigned NANO_W   = 30;

  typedef logic signed [YEAR_W-1:0] year_t;
  typedef logic [MONTH_W-1:0]       month_t;
  typedef logic [DAY_W-1:0]         day_t;
  typedef logic [HOUR_W-1:0]        hour_t;
  typedef logic [MINUTE_W-1:0]      minute_t;
  typedef logic [SECOND_W-1:0]      second_t;
  typedef logic [NANO_W-1:0]        nano_t;

  typedef enum logic {
    CMD_SET     = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_t;

  localparam year_t  YEAR_RESET = 16'sd2000;
  localparam month_t MONTH_TOP  = 4'd12;
  localparam hour_t  HOUR_TOP   = 5'd23;
  localparam minute_t MINUTE_TOP = 6'd59;
  localparam second_t SECOND_TOP = 6'd59;
  localparam nano_t  NANO_MAX   = 30'd999_999_999;
  localparam logic [NANO_W:0] NANO_PER_SEC = 31'd1_000_000_000;

  // Reciprocal of 25 scaled by 2^18, rounded up; exact for 14-bit operands
  localparam logic [13:0] RECIP_25 = 14'd10486;

  // Gregorian leap year, negative years included
  function automatic logic leap_year(input year_t y);
    logic [15:0] mag;
    logic [13:0] k;
    logic [27:0] prod;
    logic [8:0]  q;
    logic [13:0] q25;
    logic        div4;
    logic        div25;
    mag   = y[15] ? 16'(-y) : 16'(y);
    div4  = (mag[1:0] == 2'b00);
    k     = mag[15:2];
    prod  = 28'(k) * 28'(RECIP_25);
    q     = prod[26:18];
    q25   = 14'({q, 4'b0000}) + 14'({q, 3'b000}) + 14'(q);
    div25 = (q25 == k);
    return div4 && (!div25 || (k[1:0] == 2'b00));
  endfunction

  // Days in a month; codes outside 1..12 read as January
  function automatic day_t month_len(input month_t m, input logic leap);
    day_t len;
    unique case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/core/calendar_clock_advance.sv =====
// ----------------------------------------------------------------------------
// calendar_clock_advance: Gregorian calendar clock, nanosecond resolution
// Set or advance the held date and time by one beat and return it.
// ----------------------------------------------------------------------------
// A beat on the input channel either loads the whole date and time (set,
// every field clamped to its legal range, the day to the length of the
// chosen month) or adds hour, minute, second and nanosecond deltas (advance,
// each clamped too), with a single carry rippling up through second, minute,
// hour, day, month and the 16-bit wrapping year. Each input beat gives
// exactly one result beat carrying the date and time as they stand after it.
// Throughput is one beat per cycle while the result channel does not stall;
// a taken beat passes the input register, then the calendar registers. The
// clamps, the leap test of a set year and the set-day clamp sit in front of
// the input register, and the carry chain sits between the input register
// and the calendar registers. The calendar registers themselves drive the
// result ports, so they only move when the result stage is empty or its beat
// is being taken. Reset gives 1 January 2000, 00:00:00.000000000.
// ----------------------------------------------------------------------------
module calendar_clock_advance (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_command,
  input  logic signed [15:0]     in_year_value,
  input  logic [7:0]             in_month_value,
  input  logic [7:0]             in_day_value,
  input  logic [7:0]             in_hour_value,
  input  logic [7:0]             in_minute_value,
  input  logic [7:0]             in_second_value,
  input  logic [31:0]            in_nano_value,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output cca_pkg::year_t         out_cur_year,
  output cca_pkg::month_t        out_cur_month,
  output cca_pkg::day_t          out_cur_day,
  output cca_pkg::hour_t         out_cur_hour,
  output cca_pkg::minute_t       out_cur_minute,
  output cca_pkg::second_t       out_cur_second,
  output cca_pkg::nano_t         out_cur_nano
);

  import cca_pkg::*;

  // --------------------------------------------------------------------------
  // Input stage: clamp on the way in
  // --------------------------------------------------------------------------
  logic    set_leap;
  month_t  set_month;
  day_t    set_len;
  day_t    set_day;
  hour_t   hv;
  minute_t mv;
  second_t sv;
  nano_t   nv;

  always_comb begin
    hv = (in_hour_value   > 8'(HOUR_TOP))   ? HOUR_TOP   : in_hour_value[HOUR_W-1:0];
    mv = (in_minute_value > 8'(MINUTE_TOP)) ? MINUTE_TOP : in_minute_value[MINUTE_W-1:0];
    sv = (in_second_value > 8'(SECOND_TOP)) ? SECOND_TOP : in_second_value[SECOND_W-1:0];
    nv = (in_nano_value   > 32'(NANO_MAX))  ? NANO_MAX   : in_nano_value[NANO_W-1:0];

    // Month and day only matter on set; zero clamps up to 1
    priority if (in_month_value == 8'd0) begin
      set_month = 4'd1;
    end else if (in_month_value > 8'(MONTH_TOP)) begin
      set_month = MONTH_TOP;
    end else begin
      set_month = in_month_value[MONTH_W-1:0];
    end

    set_leap = leap_year(in_year_value);
    set_len  = month_len(set_month, set_leap);

    priority if (in_day_value == 8'd0) begin
      set_day = 5'd1;
    end else if (in_day_value > 8'(set_len)) begin
      set_day = set_len;
    end else begin
      set_day = in_day_value[DAY_W-1:0];
    end
  end

  // Input register
  logic    in_vld_r;
  cmd_t    cmd_r;
  year_t   set_year_r;
  logic    set_leap_r;
  month_t  set_month_r;
  day_t    set_day_r;
  hour_t   hv_r;
  minute_t mv_r;
  second_t sv_r;
  nano_t   nv_r;

  logic out_vld_r;
  logic adv;

  // The result stage moves when it is empty or its beat is being taken
  assign adv      = !out_vld_r || !out_stall;
  assign in_stall = in_vld_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      cmd_r       <= cmd_t'(in_command);
      set_year_r  <= in_year_value;
      set_leap_r  <= set_leap;
      set_month_r <= set_month;
      set_day_r   <= set_day;
      hv_r        <= hv;
      mv_r        <= mv;
      sv_r        <= sv;
      nv_r        <= nv;
    end
  end

  // --------------------------------------------------------------------------
  // Calendar registers, which are also the result register
  // --------------------------------------------------------------------------
  year_t   year_r,   year_nxt;
  logic    leap_r,   leap_nxt;
  month_t  month_r,  month_nxt;
  day_t    day_r,    day_nxt;
  hour_t   hour_r,   hour_nxt;
  minute_t minute_r, minute_nxt;
  second_t second_r, second_nxt;
  nano_t   nano_r,   nano_nxt;

  logic [NANO_W:0]     nano_sum;
  logic [SECOND_W:0]   sec_sum;
  logic [MINUTE_W:0]   min_sum;
  logic [HOUR_W:0]     hour_sum;
  logic                c_sec, c_min, c_hour, c_day;
  year_t               year_inc;

  always_comb begin
    // Carry chain for advance: at most one unit into each field
    nano_sum = {1'b0, nano_r} + {1'b0, nv_r};
    c_sec    = (nano_sum > {1'b0, NANO_MAX});
    sec_sum  = {1'b0, second_r} + {1'b0, sv_r} + (SECOND_W+1)'(c_sec);
    c_min    = (sec_sum > {1'b0, SECOND_TOP});
    min_sum  = {1'b0, minute_r} + {1'b0, mv_r} + (MINUTE_W+1)'(c_min);
    c_hour   = (min_sum > {1'b0, MINUTE_TOP});
    hour_sum = {1'b0, hour_r} + {1'b0, hv_r} + (HOUR_W+1)'(c_hour);
    c_day    = (hour_sum > {1'b0, HOUR_TOP});
    year_inc = year_r + 16'sd1;

    year_nxt   = year_r;
    leap_nxt   = leap_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    nano_nxt   = nano_r;

    unique case (cmd_r)
      CMD_SET: begin
        year_nxt   = set_year_r;
        leap_nxt   = set_leap_r;
        month_nxt  = set_month_r;
        day_nxt    = set_day_r;
        hour_nxt   = hv_r;
        minute_nxt = mv_r;
        second_nxt = sv_r;
        nano_nxt   = nv_r;
      end
      CMD_ADVANCE: begin
        nano_nxt   = c_sec  ? NANO_W'(nano_sum - NANO_PER_SEC) : nano_sum[NANO_W-1:0];
        second_nxt = c_min  ? SECOND_W'(sec_sum - 7'd60)       : sec_sum[SECOND_W-1:0];
        minute_nxt = c_hour ? MINUTE_W'(min_sum - 7'd60)       : min_sum[MINUTE_W-1:0];
        hour_nxt   = c_day  ? HOUR_W'(hour_sum - 6'd24)        : hour_sum[HOUR_W-1:0];
        if (c_day) begin
          // Day wraps to 1 past the month end, month wraps to 1 past December
          if (day_r >= month_len(month_r, leap_r)) begin
            day_nxt = 5'd1;
            if (month_r >= MONTH_TOP) begin
              month_nxt = 4'd1;
              year_nxt  = year_inc;
              leap_nxt  = leap_year(year_inc);
            end else begin
              month_nxt = month_r + 4'd1;
            end
          end else begin
            day_nxt = day_r + 5'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      year_r    <= YEAR_RESET;
      leap_r    <= leap_year(YEAR_RESET);
      month_r   <= 4'd1;
      day_r     <= 5'd1;
      hour_r    <= '0;
      minute_r  <= '0;
      second_r  <= '0;
      nano_r    <= '0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
      // Hold the calendar unless a beat passes through
      if (in_vld_r) begin
        year_r   <= year_nxt;
        leap_r   <= leap_nxt;
        month_r  <= month_nxt;
        day_r    <= day_nxt;
        hour_r   <= hour_nxt;
        minute_r <= minute_nxt;
        second_r <= second_nxt;
        nano_r   <= nano_nxt;
      end
    end
  end

  assign out_valid      = out_vld_r;
  assign out_cur_year   = year_r;
  assign out_cur_month  = month_r;
  assign out_cur_day    = day_r;
  assign out_cur_hour   = hour_r;
  assign out_cur_minute = minute_r;
  assign out_cur_second = second_r;
  assign out_cur_nano   = nano_r;

endmodule

// ===== tb/sv/calendar_clock_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_clock_checker: date and time scoreboard for the calendar clock
// Watches both channels, predicts the date and time after every input beat
// and compares each result beat with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module calendar_clock_checker
  import cca_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_command,
  input  logic signed [15:0] in_year_value,
  input  logic [7:0]         in_month_value,
  input  logic [7:0]         in_day_value,
  input  logic [7:0]         in_hour_value,
  input  logic [7:0]         in_minute_value,
  input  logic [7:0]         in_second_value,
  input  logic [31:0]        in_nano_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  year_t              out_cur_year,
  input  month_t             out_cur_month,
  input  day_t               out_cur_day,
  input  hour_t              out_cur_hour,
  input  minute_t            out_cur_minute,
  input  second_t            out_cur_second,
  input  nano_t              out_cur_nano,
  output int unsigned        fault_count,
  output int unsigned        dates_pending
);

  typedef struct packed {
    year_t   year;
    month_t  month;
    day_t    day;
    hour_t   hour;
    minute_t minute;
    second_t second;
    nano_t   nano;
  } stamp_t;

  localparam stamp_t EPOCH_STAMP = '{YEAR_RESET, 4'd1, 5'd1, '0, '0, '0, '0};

  stamp_t      clock_now;
  stamp_t      dates_due[$];
  int unsigned faults;

  function automatic bit is_leap(int y);
    if (y % 4 != 0) return 1'b0;
    if (y % 100 != 0) return 1'b1;
    return (y % 400) == 0;
  endfunction

  function automatic int days_in(int y, int m);
    int len;
    case (m)
      2:           len = is_leap(y) ? 29 : 28;
      4, 6, 9, 11: len = 30;
      default:     len = 31;
    endcase
    return len;
  endfunction

  function automatic string stamp_text(stamp_t t);
    return $sformatf("%0d-%0d-%0d %0d:%0d:%0d.%0d", $signed(t.year), t.month, t.day,
                     t.hour, t.minute, t.second, t.nano);
  endfunction

  // Date and time after one beat applied to cur
  function automatic stamp_t next_stamp(stamp_t cur, cmd_t cmd, logic signed [15:0] y_in,
                                        logic [7:0] mo_in, logic [7:0] d_in,
                                        logic [7:0] h_in, logic [7:0] mi_in,
                                        logic [7:0] s_in, logic [31:0] n_in);
    int     y, mo, d, h, mi, s, carry;
    longint n;
    stamp_t nx;
    h  = (h_in > HOUR_TOP) ? int'(HOUR_TOP) : int'(h_in);
    mi = (mi_in > MINUTE_TOP) ? int'(MINUTE_TOP) : int'(mi_in);
    s  = (s_in > SECOND_TOP) ? int'(SECOND_TOP) : int'(s_in);
    n  = (n_in > NANO_MAX) ? longint'(NANO_MAX) : longint'(n_in);
    if (cmd == CMD_SET) begin
      y  = int'(y_in);
      mo = (mo_in == 0) ? 1 : (mo_in > MONTH_TOP) ? int'(MONTH_TOP) : int'(mo_in);
      d  = (d_in == 0) ? 1 : (int'(d_in) > days_in(y, mo)) ? days_in(y, mo) : int'(d_in);
    end else begin
      y  = int'($signed(cur.year));
      mo = int'(cur.month);
      d  = int'(cur.day);
      n  = n + longint'(cur.nano);
      carry = 0;
      if (n > longint'(NANO_MAX)) begin
        n = n - longint'(NANO_PER_SEC);
        carry = 1;
      end
      s = s + int'(cur.second) + carry;
      carry = 0;
      if (s > int'(SECOND_TOP)) begin
        s = s - 60;
        carry = 1;
      end
      mi = mi + int'(cur.minute) + carry;
      carry = 0;
      if (mi > int'(MINUTE_TOP)) begin
        mi = mi - 60;
        carry = 1;
      end
      h = h + int'(cur.hour) + carry;
      carry = 0;
      if (h > int'(HOUR_TOP)) begin
        h = h - 24;
        carry = 1;
      end
      if (carry != 0) begin
        d = d + 1;
        if (d > days_in(y, mo)) begin
          d  = 1;
          mo = mo + 1;
          if (mo > int'(MONTH_TOP)) begin
            mo = 1;
            // 16-bit wrap: 32767 rolls over to -32768
            y = (y == 32767) ? -32768 : y + 1;
          end
        end
      end
    end
    nx.year   = year_t'(y);
    nx.month  = month_t'(mo);
    nx.day    = day_t'(d);
    nx.hour   = hour_t'(h);
    nx.minute = minute_t'(mi);
    nx.second = second_t'(s);
    nx.nano   = nano_t'(n);
    return nx;
  endfunction

  always @(posedge clk) begin
    stamp_t got;
    stamp_t want;
    if (!rst_n) begin
      clock_now = EPOCH_STAMP;
      dates_due.delete();
      faults = 0;
    end else begin
      // Retire the result beat first, then log the new input beat
      if (out_valid && !out_stall) begin
        got = '{out_cur_year, out_cur_month, out_cur_day, out_cur_hour,
                out_cur_minute, out_cur_second, out_cur_nano};
        if (dates_due.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("[%0t] unexpected result beat: %s", $time, stamp_text(got));
        end else begin
          want = dates_due.pop_front();
          if (got !== want) begin
            faults++;
            if (faults <= 10)
              $display("[%0t] date mismatch: expected %s got %s", $time,
                       stamp_text(want), stamp_text(got));
          end
        end
      end
      if (in_valid && !in_stall) begin
        clock_now = next_stamp(clock_now, cmd_t'(in_command), in_year_value,
                               in_month_value, in_day_value, in_hour_value,
                               in_minute_value, in_second_value, in_nano_value);
        dates_due.push_back(clock_now);
      end
    end
    fault_count   <= faults;
    dates_pending <= dates_due.size();
  end

endmodule

// ===== tb/sv/calendar_clock_advance_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_clock_advance_tb: regression bench for the calendar clock
// Drives directed and random set and advance beats in bursts against a
// stalling receiver; the checker beside the block scores every result.
// ----------------------------------------------------------------------------
module calendar_clock_advance_tb;
  import cca_pkg::*;

  localparam int unsigned RANDOM_BEATS = 900;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 10;

  logic               clk             = 1'b0;
  logic               rst_n           = 1'b0;
  logic               in_valid        = 1'b0;
  logic               in_stall;
  logic               in_command      = CMD_SET;
  logic signed [15:0] in_year_value   = '0;
  logic [7:0]         in_month_value  = '0;
  logic [7:0]         in_day_value    = '0;
  logic [7:0]         in_hour_value   = '0;
  logic [7:0]         in_minute_value = '0;
  logic [7:0]         in_second_value = '0;
  logic [31:0]        in_nano_value   = '0;
  logic               out_valid;
  logic               out_stall       = 1'b0;
  year_t              out_cur_year;
  month_t             out_cur_month;
  day_t               out_cur_day;
  hour_t              out_cur_hour;
  minute_t            out_cur_minute;
  second_t            out_cur_second;
  nano_t              out_cur_nano;

  int unsigned        fault_count;
  int unsigned        dates_pending;

  // Receiver stall pattern state
  int unsigned        stall_mode = 0;
  int unsigned        stall_left = 0;
  int unsigned        stall_phase = 0;

  calendar_clock_advance u_top (.*);

  calendar_clock_checker u_checker (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: give up on a hung run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("calendar_clock_advance regression: fail");
    $finish;
  end

  // Receiver: switch between no stall, random, heavy and periodic stalls in
  // stretches of random length so that stalls land on every pipeline phase
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_phase <= stall_phase + 1;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 1) == 0);
      2:       out_stall <= ($urandom_range(0, 7) != 0);
      default: out_stall <= ((stall_phase % 5) < 2);
    endcase
  end

  // Present one beat and hold it until the block takes it
  task automatic send_beat(input cmd_t cmd, input logic [15:0] y, input logic [7:0] mo,
                           input logic [7:0] d, input logic [7:0] h, input logic [7:0] mi,
                           input logic [7:0] s, input logic [31:0] n);
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_year_value   <= y;
    in_month_value  <= mo;
    in_day_value    <= d;
    in_hour_value   <= h;
    in_minute_value <= mi;
    in_second_value <= s;
    in_nano_value   <= n;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid for a gap of the given length
  task automatic hold_off(input int unsigned gap);
    if (gap == 0) return;
    in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  // Drop valid and hold until every predicted date has come back
  task automatic wait_dates_clear();
    in_valid <= 1'b0;
    do @(posedge clk); while (dates_pending != 0);
  endtask

  // One random beat; most are advances from legal deltas or sets parked just
  // before a day, month or year boundary so that carries ripple often
  task automatic send_random_beat();
    int unsigned pick;
    logic [15:0] y;
    logic [7:0]  mo, d, h, mi, s;
    logic [31:0] n;
    pick = $urandom_range(0, 99);
    y  = 16'($urandom);
    mo = 8'($urandom);
    d  = 8'($urandom);
    h  = 8'($urandom);
    mi = 8'($urandom);
    s  = 8'($urandom);
    n  = $urandom;
    if (pick < 35) begin
      h  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 23)) : 8'd0;
      mi = 8'($urandom_range(0, 59));
      s  = 8'($urandom_range(0, 59));
      n  = $urandom_range(0, 999999999);
      send_beat(CMD_ADVANCE, y, mo, d, h, mi, s, n);
    end else if (pick < 50) begin
      // raw deltas, often past their clamps
      send_beat(CMD_ADVANCE, y, mo, d, h, mi, s, n);
    end else if (pick < 75) begin
      case ($urandom_range(0, 3))
        0:       y = 16'(32767 - $urandom_range(0, 1));
        1:       y = 16'($urandom_range(0, 100) * 4);
        default: y = 16'($urandom);
      endcase
      if ($urandom_range(0, 3) == 0) begin
        mo = 8'd12;
        d  = 8'd31;
      end else begin
        mo = 8'($urandom_range(1, 12));
        d  = 8'($urandom_range(27, 31));
      end
      h  = 8'd23;
      mi = 8'd59;
      s  = 8'($urandom_range(58, 59));
      n  = 999999999 - $urandom_range(0, 1000);
      send_beat(CMD_SET, y, mo, d, h, mi, s, n);
    end else if (pick < 90) begin
      send_beat(CMD_SET, y, 8'($urandom_range(1, 12)), 8'($urandom_range(1, 31)),
                8'($urandom_range(0, 23)), 8'($urandom_range(0, 59)),
                8'($urandom_range(0, 59)), $urandom_range(0, 999999999));
    end else begin
      send_beat(CMD_SET, y, mo, d, h, mi, s, n);
    end
  endtask

  initial begin
    int unsigned burst_left;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: clamps, leap rules, carries and the year wrap
    send_beat(CMD_ADVANCE, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0);
    send_beat(CMD_SET, 16'sd32767, 8'd12, 8'd31, 8'd23, 8'd59, 8'd59, 32'd999999999);
    send_beat(CMD_ADVANCE, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'd1);
    send_beat(CMD_SET, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    send_beat(CMD_ADVANCE, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    hold_off(3);
    send_beat(CMD_SET, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0);
    send_beat(CMD_SET, 16'd2024, 8'd2, 8'd31, 8'd0, 8'd0, 8'd0, 32'd0);
    send_beat(CMD_SET, 16'd1900, 8'd2, 8'd30, 8'd0, 8'd0, 8'd0, 32'd0);
    send_beat(CMD_SET, 16'd2000, 8'd2, 8'd30, 8'd0, 8'd0, 8'd0, 32'd0);
    send_beat(CMD_SET, -16'sd4, 8'd2, 8'd31, 8'd0, 8'd0, 8'd0, 32'd0);
    send_beat(CMD_SET, -16'sd100, 8'd2, 8'd29, 8'd0, 8'd0, 8'd0, 32'd0);
    send_beat(CMD_SET, -16'sd400, 8'd2, 8'd29, 8'd0, 8'd0, 8'd0, 32'd0);
    hold_off(1);
    send_beat(CMD_SET, 16'd2023, 8'd2, 8'd28, 8'd23, 8'd59, 8'd59, 32'd999999999);
    send_beat(CMD_ADVANCE, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'd1);
    send_beat(CMD_SET, 16'd2024, 8'd2, 8'd28, 8'd23, 8'd59, 8'd59, 32'd999999999);
    send_beat(CMD_ADVANCE, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'd1);
    send_beat(CMD_ADVANCE, 16'd0, 8'd0, 8'd0, 8'd23, 8'd59, 8'd59, 32'd999999999);
    send_beat(CMD_ADVANCE, 16'd0, 8'd0, 8'd0, 8'd23, 8'd59, 8'd59, 32'd999999999);
    send_beat(CMD_SET, 16'd2023, 8'd4, 8'd30, 8'd23, 8'd59, 8'd59, 32'd999999999);
    send_beat(CMD_ADVANCE, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 32'd0);
    send_beat(CMD_SET, 16'h8000, 8'd6, 8'd15, 8'd12, 8'd30, 8'd30, 32'd500000000);
    send_beat(CMD_ADVANCE, 16'd0, 8'd0, 8'd0, 8'd12, 8'd30, 8'd30, 32'd500000000);
    // just past every clamp
    send_beat(CMD_SET, 16'd1999, 8'd13, 8'd32, 8'd24, 8'd60, 8'd60, 32'd1000000000);
    send_beat(CMD_ADVANCE, 16'd0, 8'd0, 8'd0, 8'd24, 8'd60, 8'd60, 32'd1000000000);

    // Let the pipeline run dry before the random part
    wait_dates_clear();

    // Random beats in bursts with gaps; some long bursts give idle-free runs
    burst_left = 0;
    for (int unsigned i = 0; i < RANDOM_BEATS; i++) begin
      if (i == RANDOM_BEATS / 2) wait_dates_clear();
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 16);
        hold_off(($urandom_range(0, 4) == 0) ? $urandom_range(4, 12)
                                              : $urandom_range(0, 3));
      end
      send_random_beat();
      burst_left--;
    end

    // Drain: wait for the last dates, then a few more cycles for strays
    wait_dates_clear();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("calendar_clock_advance regression: pass");
    end else begin
      $display("calendar_clock_advance regression: fail");
    end
    $finish;
  end

endmodule
